// ===== design/uebt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Energy budget tracker package
// Shared widths, payload types, command codes and controller interface types.
// ----------------------------------------------------------------------------
package uebt_pkg;

  localparam int EW         = 48;
  localparam int AMT_W      = 32;
  localparam int SPD_W      = 16;
  localparam int FRAC_W     = 8;
  localparam int SPD_ONE    = 1 << FRAC_W;
  localparam int SH2        = 2 * FRAC_W;
  localparam int SH3        = 3 * FRAC_W;
  localparam int TX_SH      = 8;
  localparam int MCAND_W    = 64;
  localparam int MPLR_W     = 32;
  localparam int PROD_W     = MCAND_W + MPLR_W;
  localparam int CNT_W      = 6;
  localparam int DIVD_W     = 32 + FRAC_W;
  localparam int DIVS_W     = SPD_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int CPU_W      = 16;

  localparam logic [EW-1:0]    INIT_RESET  = 48'd50000000000000;
  localparam logic [CPU_W-1:0] CPU_RESET   = 16'd100;
  localparam logic [CNT_W-1:0] STEPS_HALF  = CNT_W'(16);
  localparam logic [CNT_W-1:0] STEPS_FULL  = CNT_W'(32);
  localparam logic [CNT_W-1:0] STEPS_DIV   = CNT_W'(DIVD_W);

  typedef enum logic [1:0] {
    CMD_FLIGHT   = 2'd0,
    CMD_COMPUTE  = 2'd1,
    CMD_TRANSMIT = 2'd2,
    CMD_RESET    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL  = 3'd0,
    REG_BLADE    = 3'd1,
    REG_BLADE_K  = 3'd2,
    REG_INDUCED  = 3'd3,
    REG_PARASITE = 3'd4,
    REG_CPU      = 3'd5,
    REG_TX       = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MOP_SS,
    MOP_BK,
    MOP_PS,
    MOP_PSS,
    MOP_CPU,
    MOP_TX
  } mop_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    cmd_t              command;
    logic [AMT_W-1:0]  amount;
  } in_item_t;

  typedef struct packed {
    logic [EW-1:0] remaining_energy;
    logic [EW-1:0] total_consumed;
    logic          alive;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic mul_go;
    logic div_go;
    logic hover_take;
    logic commit;
    mop_t mop;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t command;
    logic hover;
    logic alive;
    logic mul_done;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== design/uav_energy_budget_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UAV energy budget tracker
// Each input word is a flight tick, a compute charge, a transmit charge or a
// reset. Each produces one output word with the energy left, the saturating
// total consumed and an alive flag.
//
// The input channel takes a word only when the block is idle. A reset, a
// hover tick or a charge on an empty battery goes from decode straight to
// the final step. A compute or a transmit charge takes one pass through
// the shared one-bit-per-cycle multiplier; a moving flight tick takes four
// passes through it followed by the restoring divider. The result sits in
// an output register; the next word is accepted while it waits. If the
// receiver stalls and a newer result is ready, the block holds in its final
// step until the register frees. A synchronous reset loads the initial
// energy and the register defaults and clears the total; no result is
// pending after reset. Configuration writes are always ready and should be
// made only while the block is idle.
// ----------------------------------------------------------------------------
module uav_energy_budget_tracker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire uebt_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output uebt_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [uebt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [uebt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  uebt_pkg::dp_cmd_t dp_cmd;
  uebt_pkg::dp_sts_t dp_sts;

  assign cfg_ready = 1'b1;

  uebt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  uebt_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_data  (out_data),
    .out_valid (out_valid),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

endmodule
`default_nettype wire

// ===== design/uebt_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative multiplier
// Shift-add multiplier taking one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module uebt_mul (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          go,
  input  wire logic [uebt_pkg::MCAND_W-1:0]  mcand,
  input  wire logic [uebt_pkg::MPLR_W-1:0]   mplier,
  input  wire logic [uebt_pkg::CNT_W-1:0]    steps,
  output logic      [uebt_pkg::PROD_W-1:0]   prod,
  output logic                               done
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [uebt_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [uebt_pkg::PROD_W-1:0]   acc_r, acc_nxt;
  logic [uebt_pkg::MCAND_W-1:0]  mcand_r, mcand_nxt;
  logic [uebt_pkg::MPLR_W-1:0]   mplier_r, mplier_nxt;

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    if (go) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = steps;
      acc_nxt    = '0;
      mcand_nxt  = mcand;
      mplier_nxt = mplier;
    end else if (busy_r) begin
      acc_nxt    = {acc_r[uebt_pkg::PROD_W-2:0], 1'b0} +
                   (mplier_r[uebt_pkg::MPLR_W-1] ? uebt_pkg::PROD_W'(mcand_r)
                                                 : '0);
      mplier_nxt = {mplier_r[uebt_pkg::MPLR_W-2:0], 1'b0};
      cnt_nxt    = cnt_r - 1'b1;
      if (cnt_r == uebt_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ===== design/uebt_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module uebt_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         go,
  input  wire logic [uebt_pkg::DIVD_W-1:0]  dividend,
  input  wire logic [uebt_pkg::DIVS_W-1:0]  divisor,
  output logic      [uebt_pkg::DIVD_W-1:0]  quot,
  output logic                              done
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [uebt_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [uebt_pkg::DIVS_W:0]     rem_r, rem_nxt;
  logic [uebt_pkg::DIVD_W-1:0]   quo_r, quo_nxt;
  logic [uebt_pkg::DIVS_W-1:0]   dvs_r, dvs_nxt;
  logic [uebt_pkg::DIVS_W:0]     rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r[uebt_pkg::DIVS_W-1:0], quo_r[uebt_pkg::DIVD_W-1]};
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = uebt_pkg::STEPS_DIV;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        quo_nxt = {quo_r[uebt_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[uebt_pkg::DIVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == uebt_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quot = quo_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ===== design/uebt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Energy budget datapath
// Configuration registers, charge arithmetic, energy state and output word.
// ----------------------------------------------------------------------------
module uebt_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  input  wire logic [uebt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [uebt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire uebt_pkg::in_item_t               in_data,
  input  wire logic                             out_stall,
  output uebt_pkg::out_item_t                   out_data,
  output logic                                  out_valid,
  input  wire uebt_pkg::dp_cmd_t                cmd,
  output uebt_pkg::dp_sts_t                     sts
);

  localparam int EW = uebt_pkg::EW;

  function automatic logic [EW-1:0] sat_add(input logic [EW-1:0] a,
                                            input logic [EW-1:0] b);
    logic [EW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[EW] ? '1 : s[EW-1:0];
  endfunction

  logic [EW-1:0]                  init_r;
  logic [31:0]                    blade_r, blade_k_r, induced_r, parasite_r, tx_r;
  logic [uebt_pkg::CPU_W-1:0]     cpu_r;

  uebt_pkg::cmd_t                 command_r;
  logic [uebt_pkg::AMT_W-1:0]     amount_r;
  logic [uebt_pkg::SPD_W-1:0]     s_r;
  logic [uebt_pkg::SPD_W+3:0]     s10;

  logic [2*uebt_pkg::SPD_W-1:0]   ss_r, ss_nxt;
  logic [uebt_pkg::MCAND_W-1:0]   pss_r, pss_nxt;
  logic [EW-1:0]                  charge_r, charge_nxt;
  logic [EW-1:0]                  left_r, left_nxt, used_r, used_nxt;
  uebt_pkg::out_item_t            out_data_r, out_data_nxt;
  logic                           out_valid_r, out_valid_nxt;

  logic [uebt_pkg::MCAND_W-1:0]   mul_mcand;
  logic [uebt_pkg::MPLR_W-1:0]    mul_mplier;
  logic [uebt_pkg::CNT_W-1:0]     mul_steps;
  logic [uebt_pkg::PROD_W-1:0]    prod;
  logic                           mul_done;
  logic [uebt_pkg::DIVD_W-1:0]    quot;
  logic                           div_done;
  logic [uebt_pkg::MPLR_W-uebt_pkg::SPD_W-1:0] pad_lo;

  assign pad_lo = '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r     <= uebt_pkg::INIT_RESET;
      blade_r    <= '0;
      blade_k_r  <= '0;
      induced_r  <= '0;
      parasite_r <= '0;
      cpu_r      <= uebt_pkg::CPU_RESET;
      tx_r       <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        uebt_pkg::REG_INITIAL:  init_r     <= cfg_data[EW-1:0];
        uebt_pkg::REG_BLADE:    blade_r    <= cfg_data[31:0];
        uebt_pkg::REG_BLADE_K:  blade_k_r  <= cfg_data[31:0];
        uebt_pkg::REG_INDUCED:  induced_r  <= cfg_data[31:0];
        uebt_pkg::REG_PARASITE: parasite_r <= cfg_data[31:0];
        uebt_pkg::REG_CPU:      cpu_r      <= cfg_data[uebt_pkg::CPU_W-1:0];
        uebt_pkg::REG_TX:       tx_r       <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command_r <= in_data.command;
      amount_r  <= in_data.amount;
      s_r       <= (|in_data.amount[uebt_pkg::AMT_W-1:uebt_pkg::SPD_W]) ? '1
                   : in_data.amount[uebt_pkg::SPD_W-1:0];
    end
  end

  assign s10 = ({4'b0, s_r} << 3) + ({4'b0, s_r} << 1);

  always_comb begin
    mul_mcand  = '0;
    mul_mplier = '0;
    mul_steps  = uebt_pkg::STEPS_FULL;
    unique case (cmd.mop)
      uebt_pkg::MOP_SS: begin
        mul_mcand  = uebt_pkg::MCAND_W'(s_r);
        mul_mplier = {s_r, pad_lo};
        mul_steps  = uebt_pkg::STEPS_HALF;
      end
      uebt_pkg::MOP_BK: begin
        mul_mcand  = uebt_pkg::MCAND_W'(blade_k_r);
        mul_mplier = ss_r;
      end
      uebt_pkg::MOP_PS: begin
        mul_mcand  = uebt_pkg::MCAND_W'(parasite_r);
        mul_mplier = ss_r;
      end
      uebt_pkg::MOP_PSS: begin
        mul_mcand  = pss_r;
        mul_mplier = {s_r, pad_lo};
        mul_steps  = uebt_pkg::STEPS_HALF;
      end
      uebt_pkg::MOP_CPU: begin
        mul_mcand  = uebt_pkg::MCAND_W'(amount_r);
        mul_mplier = {cpu_r, pad_lo};
        mul_steps  = uebt_pkg::STEPS_HALF;
      end
      uebt_pkg::MOP_TX: begin
        mul_mcand  = uebt_pkg::MCAND_W'(amount_r);
        mul_mplier = tx_r;
      end
      default: ;
    endcase
  end

  uebt_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (cmd.mul_go),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .steps  (mul_steps),
    .prod   (prod),
    .done   (mul_done)
  );

  uebt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend ({induced_r, {uebt_pkg::FRAC_W{1'b0}}}),
    .divisor  (uebt_pkg::DIVS_W'(uebt_pkg::SPD_ONE) + {1'b0, s_r}),
    .quot     (quot),
    .done     (div_done)
  );

  always_comb begin
    ss_nxt     = ss_r;
    pss_nxt    = pss_r;
    charge_nxt = charge_r;
    if (cmd.hover_take) begin
      charge_nxt = sat_add(EW'(blade_r), EW'(induced_r));
    end else if (mul_done) begin
      unique case (cmd.mop)
        uebt_pkg::MOP_SS:  ss_nxt = prod[2*uebt_pkg::SPD_W-1:0];
        uebt_pkg::MOP_BK:  charge_nxt = sat_add(EW'(blade_r),
                                                prod[EW+uebt_pkg::SH2-1:uebt_pkg::SH2]);
        uebt_pkg::MOP_PS:  pss_nxt = prod[uebt_pkg::MCAND_W-1:0];
        uebt_pkg::MOP_PSS: charge_nxt = sat_add(charge_r,
            (|prod[uebt_pkg::PROD_W-1:EW+uebt_pkg::SH3]) ? '1
            : prod[EW+uebt_pkg::SH3-1:uebt_pkg::SH3]);
        uebt_pkg::MOP_CPU: charge_nxt = prod[EW-1:0];
        uebt_pkg::MOP_TX:  charge_nxt =
            (|prod[uebt_pkg::PROD_W-1:EW+uebt_pkg::TX_SH]) ? '1
            : prod[EW+uebt_pkg::TX_SH-1:uebt_pkg::TX_SH];
        default: ;
      endcase
    end else if (div_done) begin
      charge_nxt = sat_add(charge_r, EW'(quot));
    end
  end

  always_ff @(posedge clk) begin
    ss_r     <= ss_nxt;
    pss_r    <= pss_nxt;
    charge_r <= charge_nxt;
  end

  always_comb begin
    left_nxt      = left_r;
    used_nxt      = used_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.commit) begin
      if (command_r == uebt_pkg::CMD_RESET) begin
        left_nxt = init_r;
        used_nxt = '0;
      end else if (left_r != '0) begin
        left_nxt = (charge_r >= left_r) ? '0 : left_r - charge_r;
        used_nxt = sat_add(used_r, charge_r);
      end
      out_data_nxt.remaining_energy = left_nxt;
      out_data_nxt.total_consumed   = used_nxt;
      out_data_nxt.alive            = (left_nxt != '0);
      out_valid_nxt                 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= uebt_pkg::INIT_RESET;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      left_r      <= left_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_data  = out_data_r;
  assign out_valid = out_valid_r;

  assign sts.command  = command_r;
  assign sts.hover    = (s10 < (uebt_pkg::SPD_W+4)'(uebt_pkg::SPD_ONE));
  assign sts.alive    = (left_r != '0);
  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule
`default_nettype wire

// ===== design/uebt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Energy budget controller
// Sequences the multiplies, the divide and the state update for one word.
// ----------------------------------------------------------------------------
module uebt_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire uebt_pkg::dp_sts_t    sts,
  output uebt_pkg::dp_cmd_t         cmd
);

  uebt_pkg::state_t state_r, state_nxt;
  uebt_pkg::mop_t   mop_r, mop_nxt;

  always_comb begin
    state_nxt = state_r;
    mop_nxt   = mop_r;
    unique case (state_r)
      uebt_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = uebt_pkg::ST_DECODE;
      end
      uebt_pkg::ST_DECODE: begin
        if (sts.command == uebt_pkg::CMD_RESET || !sts.alive) begin
          state_nxt = uebt_pkg::ST_FINISH;
        end else begin
          unique case (sts.command)
            uebt_pkg::CMD_FLIGHT: begin
              if (sts.hover) begin
                state_nxt = uebt_pkg::ST_FINISH;
              end else begin
                mop_nxt   = uebt_pkg::MOP_SS;
                state_nxt = uebt_pkg::ST_MUL_GO;
              end
            end
            uebt_pkg::CMD_COMPUTE: begin
              mop_nxt   = uebt_pkg::MOP_CPU;
              state_nxt = uebt_pkg::ST_MUL_GO;
            end
            default: begin
              mop_nxt   = uebt_pkg::MOP_TX;
              state_nxt = uebt_pkg::ST_MUL_GO;
            end
          endcase
        end
      end
      uebt_pkg::ST_MUL_GO: state_nxt = uebt_pkg::ST_MUL_WAIT;
      uebt_pkg::ST_MUL_WAIT: begin
        if (sts.mul_done) begin
          unique case (mop_r)
            uebt_pkg::MOP_SS: begin
              mop_nxt   = uebt_pkg::MOP_BK;
              state_nxt = uebt_pkg::ST_MUL_GO;
            end
            uebt_pkg::MOP_BK: begin
              mop_nxt   = uebt_pkg::MOP_PS;
              state_nxt = uebt_pkg::ST_MUL_GO;
            end
            uebt_pkg::MOP_PS: begin
              mop_nxt   = uebt_pkg::MOP_PSS;
              state_nxt = uebt_pkg::ST_MUL_GO;
            end
            uebt_pkg::MOP_PSS: state_nxt = uebt_pkg::ST_DIV_GO;
            default:           state_nxt = uebt_pkg::ST_FINISH;
          endcase
        end
      end
      uebt_pkg::ST_DIV_GO: state_nxt = uebt_pkg::ST_DIV_WAIT;
      uebt_pkg::ST_DIV_WAIT: begin
        if (sts.div_done) state_nxt = uebt_pkg::ST_FINISH;
      end
      uebt_pkg::ST_FINISH: begin
        if (sts.out_free) state_nxt = uebt_pkg::ST_IDLE;
      end
      default: state_nxt = uebt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.mop  = mop_r;
    in_stall = 1'b1;
    unique case (state_r)
      uebt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      uebt_pkg::ST_DECODE: begin
        cmd.hover_take = (sts.command == uebt_pkg::CMD_FLIGHT) && sts.hover;
      end
      uebt_pkg::ST_MUL_GO:   cmd.mul_go = 1'b1;
      uebt_pkg::ST_MUL_WAIT: ;
      uebt_pkg::ST_DIV_GO:   cmd.div_go = 1'b1;
      uebt_pkg::ST_DIV_WAIT: ;
      uebt_pkg::ST_FINISH:   cmd.commit = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= uebt_pkg::ST_IDLE;
      mop_r   <= uebt_pkg::MOP_SS;
    end else begin
      state_r <= state_nxt;
      mop_r   <= mop_nxt;
    end
  end

endmodule
`default_nettype wire
